>>> rtl/fmg_pkg.sv
// fmg_pkg: types and constants for the fuzzy membership grade unit.
// No dependencies; used by fuzzy_membership_grade_unit.
package fmg_pkg;

  localparam int VAL_W     = 16;
  localparam int GRADE_W   = 9;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;
  localparam int MAX_POINTS = 3;
  localparam int PROD_W    = VAL_W + GRADE_W;
  localparam int DIV_STEPS = GRADE_W;

  typedef logic signed [VAL_W-1:0] pt_t;
  typedef logic [GRADE_W-1:0]      grade_t;
  typedef logic [CFG_IDX_W-1:0]    cfg_idx_t;
  typedef logic [VAL_W-1:0]        dist_t;
  typedef logic [PROD_W-1:0]       prod_t;

  localparam cfg_idx_t CFG_POINT_0 = 3'd0;
  localparam cfg_idx_t CFG_GRADE_0 = 3'd3;

  localparam pt_t    POINT_RESET [MAX_POINTS] = '{16'sd3840, 16'sd4608, 16'sd5120};
  localparam grade_t GRADE_RESET [MAX_POINTS] = '{9'd256, 9'd256, 9'd0};

  typedef struct packed {
    pt_t    q;
    pt_t    xa;
    pt_t    xb;
    grade_t ya;
    grade_t yb;
    logic   is_const;
    grade_t cval;
  } seg_t;

  typedef struct packed {
    dist_t  a;
    grade_t dy;
    dist_t  dx;
    grade_t base;
    logic   is_const;
    grade_t cval;
  } prep_t;

  typedef struct packed {
    prod_t  rem;
    dist_t  dx;
    grade_t quo;
    grade_t base;
    logic   is_const;
    grade_t cval;
  } div_t;

endpackage

>>> rtl/fuzzy_membership_grade_unit.sv
// fuzzy_membership_grade_unit: piecewise-linear membership grade, pipelined.
// Depends on fmg_pkg.
//
//   channel   signals                               role
//   in        in_valid, in_ready, query_value       value to grade, Q8.8 signed
//   out       out_valid, out_ready, membership      grade in 1/256 units
//   cfg       cfg_write, cfg_index, cfg_data        breakpoints and grades
//
// One transfer per cycle unless stalled. Stages: segment select, operand prep,
// multiply, nine restoring-divide steps (one quotient bit each), output add.
// Reset clears all valid bits and restores the breakpoint and grade registers.
// Each stage holds while the stage after it is full and held; bubbles collapse.
module fuzzy_membership_grade_unit #(
  parameter int NUM_POINTS = 3
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [fmg_pkg::VAL_W-1:0] query_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fmg_pkg::GRADE_W-1:0]   membership,
  input  logic                          cfg_write,
  input  logic [fmg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fmg_pkg::CFG_W-1:0]     cfg_data
);

  localparam int NSTAGE   = fmg_pkg::DIV_STEPS + 4;
  localparam int DIV_BASE = 3;

  fmg_pkg::pt_t    points [NUM_POINTS];
  fmg_pkg::grade_t grades [NUM_POINTS];

  logic vld [NSTAGE];
  logic rdy [NSTAGE];

  fmg_pkg::seg_t  s1, s1_next;
  fmg_pkg::prep_t s2, s2_next;
  fmg_pkg::div_t  dv [fmg_pkg::DIV_STEPS+1];
  fmg_pkg::grade_t out_grade;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_POINTS; i++) begin
        points[i] <= fmg_pkg::POINT_RESET[i];
        grades[i] <= fmg_pkg::GRADE_RESET[i];
      end
    end else if (cfg_write) begin
      for (int i = 0; i < NUM_POINTS; i++) begin
        if (cfg_index == fmg_pkg::cfg_idx_t'(fmg_pkg::CFG_POINT_0 + fmg_pkg::cfg_idx_t'(i)))
          points[i] <= cfg_data[fmg_pkg::VAL_W-1:0];
        if (cfg_index == fmg_pkg::cfg_idx_t'(fmg_pkg::CFG_GRADE_0 + fmg_pkg::cfg_idx_t'(i)))
          grades[i] <= cfg_data[fmg_pkg::GRADE_W-1:0];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NSTAGE - 1; k++)
      rdy[k] = !vld[k] || rdy[k+1];
    rdy[NSTAGE-1] = !vld[NSTAGE-1] || out_ready;
  end

  assign in_ready   = rdy[0];
  assign out_valid  = vld[NSTAGE-1];
  assign membership = out_grade;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NSTAGE; k++)
        vld[k] <= 1'b0;
    end else begin
      if (rdy[0])
        vld[0] <= in_valid;
      for (int k = 1; k < NSTAGE; k++)
        if (rdy[k])
          vld[k] <= vld[k-1];
    end
  end

  // Segment select
  always_comb begin
    logic found;
    found            = 1'b0;
    s1_next.q        = query_value;
    s1_next.xa       = points[0];
    s1_next.xb       = points[0];
    s1_next.ya       = grades[0];
    s1_next.yb       = grades[0];
    s1_next.is_const = 1'b1;
    s1_next.cval     = grades[NUM_POINTS-1];
    if (query_value < points[0]) begin
      found        = 1'b1;
      s1_next.cval = grades[0];
    end
    for (int i = 0; i < NUM_POINTS - 1; i++) begin
      if (!found && query_value >= points[i] && query_value <= points[i+1]) begin
        found            = 1'b1;
        s1_next.xa       = points[i];
        s1_next.xb       = points[i+1];
        s1_next.ya       = grades[i];
        s1_next.yb       = grades[i+1];
        s1_next.is_const = 1'b0;
      end
    end
  end

  // Operand prep
  always_comb begin
    logic signed [fmg_pkg::VAL_W:0] up, down, span;
    logic rising, flat;
    up     = {s1.q[fmg_pkg::VAL_W-1], s1.q} - {s1.xa[fmg_pkg::VAL_W-1], s1.xa};
    down   = {s1.xb[fmg_pkg::VAL_W-1], s1.xb} - {s1.q[fmg_pkg::VAL_W-1], s1.q};
    span   = {s1.xb[fmg_pkg::VAL_W-1], s1.xb} - {s1.xa[fmg_pkg::VAL_W-1], s1.xa};
    rising = s1.ya < s1.yb;
    flat   = (s1.xa == s1.xb) || (s1.ya == s1.yb);
    s2_next.a        = rising ? up[fmg_pkg::VAL_W-1:0] : down[fmg_pkg::VAL_W-1:0];
    s2_next.dy       = rising ? s1.yb - s1.ya : s1.ya - s1.yb;
    s2_next.dx       = span[fmg_pkg::VAL_W-1:0];
    s2_next.base     = rising ? s1.ya : s1.yb;
    s2_next.is_const = s1.is_const || flat;
    s2_next.cval     = s1.is_const ? s1.cval : s1.ya;
  end

  always_ff @(posedge clk) begin
    if (rdy[0])
      s1 <= s1_next;
    if (rdy[1])
      s2 <= s2_next;
    if (rdy[2]) begin
      dv[0].rem      <= {{fmg_pkg::GRADE_W{1'b0}}, s2.a} *
                        {{fmg_pkg::VAL_W{1'b0}}, s2.dy};
      dv[0].dx       <= s2.dx;
      dv[0].quo      <= '0;
      dv[0].base     <= s2.base;
      dv[0].is_const <= s2.is_const;
      dv[0].cval     <= s2.cval;
    end
  end

  for (genvar j = 0; j < fmg_pkg::DIV_STEPS; j++) begin : g_div
    localparam int SHIFT = fmg_pkg::DIV_STEPS - 1 - j;
    fmg_pkg::prod_t sub;
    logic           ge;
    assign sub = {{fmg_pkg::GRADE_W{1'b0}}, dv[j].dx} << SHIFT;
    assign ge  = dv[j].rem >= sub;
    always_ff @(posedge clk) begin
      if (rdy[DIV_BASE+j]) begin
        dv[j+1].rem      <= ge ? dv[j].rem - sub : dv[j].rem;
        dv[j+1].dx       <= dv[j].dx;
        dv[j+1].quo      <= {dv[j].quo[fmg_pkg::GRADE_W-2:0], ge};
        dv[j+1].base     <= dv[j].base;
        dv[j+1].is_const <= dv[j].is_const;
        dv[j+1].cval     <= dv[j].cval;
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [fmg_pkg::GRADE_W:0] sum;
    sum = {1'b0, dv[fmg_pkg::DIV_STEPS].base} + {1'b0, dv[fmg_pkg::DIV_STEPS].quo};
    if (rdy[NSTAGE-1])
      out_grade <= dv[fmg_pkg::DIV_STEPS].is_const ? dv[fmg_pkg::DIV_STEPS].cval
                                                   : sum[fmg_pkg::GRADE_W-1:0];
  end

endmodule
